/* hdl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    // Most result bytes one input byte can cause
    localparam int MAX_RES = 8;
    localparam int RES_CNT_W = 4;

    // Decoder modes
    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX1    = 3'd2;
    localparam logic [2:0] MODE_HI_WAIT = 3'd3;
    localparam logic [2:0] MODE_HI_ESC  = 3'd4;
    localparam logic [2:0] MODE_HEX2    = 3'd5;

    // Characters of the string syntax
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // Control characters the simple escapes stand for
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    // Surrogate ranges
    localparam logic [15:0] HI_SURR_MIN  = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX  = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX  = 16'hDFFF;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
    localparam logic [20:0] SUPPL_BASE   = 21'h10000;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } res_t;

    // All results of one input byte, first at index 0
    typedef struct packed {
        res_t [MAX_RES-1:0]   item;
        logic [RES_CNT_W-1:0] n;
    } dec_out_t;

endpackage

/* hdl/jsu_decode.sv */
// Escape decoder: state registers and the per-byte result list.
module jsu_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    output jsu_pkg::dec_out_t res
);
    import jsu_pkg::*;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } enc_t;

    // UTF-8 encode of one code point, first byte at index 0
    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.len  = 3'd1;
            e.b[0] = {1'b0, cp[6:0]};
        end else if (cp <= 21'h7FF) begin
            e.len  = 3'd2;
            e.b[0] = 8'hC0 | {3'b0, cp[10:6]};
            e.b[1] = 8'h80 | {2'b0, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            e.len  = 3'd3;
            e.b[0] = 8'hE0 | {4'b0, cp[15:12]};
            e.b[1] = 8'h80 | {2'b0, cp[11:6]};
            e.b[2] = 8'h80 | {2'b0, cp[5:0]};
        end else begin
            e.len  = 3'd4;
            e.b[0] = 8'hF0 | {5'b0, cp[20:18]};
            e.b[1] = 8'h80 | {2'b0, cp[17:12]};
            e.b[2] = 8'h80 | {2'b0, cp[11:6]};
            e.b[3] = 8'h80 | {2'b0, cp[5:0]};
        end
        return e;
    endfunction

    // State: at most three hex digits are ever held between bytes
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  held_reg, held_next;
    logic [2:0]  case_reg, case_next;
    logic        done_reg, done_next;

    logic        is_hex, hex_lower;
    logic [3:0]  hex_v;
    logic [15:0] acc_ext;
    logic [2:0]  case_set;
    logic        low_ok, high_ok;

    logic        do_hex1, do_esc, do_plain;
    logic        emit_hi, cp_en, byte_en, fin_en;
    logic [20:0] cp_val;
    logic [7:0]  byte_val;
    logic [1:0]  flush_n;
    logic [11:0] flush_val;
    logic [2:0]  flush_case;

    enc_t        hi_enc, cp_enc;
    logic [RES_CNT_W-1:0] idx;
    logic [1:0]  pos;
    logic [3:0]  dig;

    // Classify the byte as a hex digit
    always_comb begin
        is_hex    = 1'b1;
        hex_lower = 1'b0;
        hex_v     = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_v = in_byte[3:0];
        end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
            hex_lower = 1'b1;
            hex_v     = 4'(in_byte - 8'h57);
        end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
            hex_v = 4'(in_byte - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign acc_ext  = {acc_reg, hex_v};
    assign case_set = (case_reg & ~(3'b001 << cnt_reg)) | ({2'b00, hex_lower} << cnt_reg);
    assign low_ok   = (acc_ext >= LO_SURR_MIN) && (acc_ext <= LO_SURR_MAX);
    assign high_ok  = (acc_ext >= HI_SURR_MIN) && (acc_ext <= HI_SURR_MAX);

    // Next state and which result groups this byte causes
    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        case_next  = case_reg;
        done_next  = done_reg;
        do_hex1    = 1'b0;
        do_esc     = 1'b0;
        do_plain   = 1'b0;
        emit_hi    = 1'b0;
        cp_en      = 1'b0;
        cp_val     = '0;
        byte_en    = 1'b0;
        byte_val   = in_byte;
        fin_en     = 1'b0;
        flush_n    = 2'd0;
        flush_val  = acc_reg;
        flush_case = case_reg;
        if (!done_reg) begin
            case (mode_reg)
                MODE_HEX2: begin
                    if (is_hex && cnt_reg == 2'd3 && low_ok) begin
                        cp_en     = 1'b1;
                        cp_val    = SUPPL_BASE + {1'b0, held_reg, acc_ext[9:0]};
                        mode_next = MODE_PLAIN;
                        cnt_next  = 2'd0;
                        fin_en    = end_of_input;
                    end else if (is_hex && cnt_reg != 2'd3 && !end_of_input) begin
                        acc_next  = acc_ext[11:0];
                        case_next = case_set;
                        cnt_next  = cnt_reg + 2'd1;
                    end else begin
                        // not a low surrogate: release the high one, reparse
                        emit_hi = 1'b1;
                        do_hex1 = 1'b1;
                    end
                end
                MODE_HEX1: do_hex1 = 1'b1;
                MODE_HI_WAIT: begin
                    if (in_byte == CH_BSLASH && !end_of_input) begin
                        mode_next = MODE_HI_ESC;
                    end else begin
                        emit_hi  = 1'b1;
                        do_plain = 1'b1;
                    end
                end
                MODE_HI_ESC: begin
                    if (in_byte == CH_U && !end_of_input) begin
                        mode_next = MODE_HEX2;
                        cnt_next  = 2'd0;
                        acc_next  = '0;
                        case_next = '0;
                    end else begin
                        emit_hi = 1'b1;
                        do_esc  = 1'b1;
                    end
                end
                MODE_ESC: do_esc = 1'b1;
                default: do_plain = 1'b1;
            endcase

            // Gather a hex digit of a \u escape
            if (do_hex1) begin
                if (!is_hex) begin
                    flush_n  = cnt_reg;
                    do_plain = 1'b1;
                end else if (cnt_reg != 2'd3) begin
                    acc_next  = acc_ext[11:0];
                    case_next = case_set;
                    cnt_next  = cnt_reg + 2'd1;
                    mode_next = MODE_HEX1;
                    if (end_of_input) begin
                        flush_n    = cnt_reg + 2'd1;
                        flush_val  = acc_ext[11:0];
                        flush_case = case_set;
                        fin_en     = 1'b1;
                    end
                end else begin
                    cnt_next  = 2'd0;
                    mode_next = MODE_PLAIN;
                    if (high_ok && !end_of_input) begin
                        held_next = acc_ext[9:0];
                        mode_next = MODE_HI_WAIT;
                    end else begin
                        cp_en  = 1'b1;
                        cp_val = {5'b0, acc_ext};
                        fin_en = end_of_input;
                    end
                end
            end

            // Byte after a backslash
            if (do_esc) begin
                mode_next = MODE_PLAIN;
                if (in_byte == CH_U) begin
                    if (end_of_input) begin
                        fin_en = 1'b1;
                    end else begin
                        mode_next = MODE_HEX1;
                        cnt_next  = 2'd0;
                        acc_next  = '0;
                        case_next = '0;
                    end
                end else begin
                    byte_en = 1'b1;
                    case (in_byte)
                        CH_B:    byte_val = CTL_BS;
                        CH_F:    byte_val = CTL_FF;
                        CH_N:    byte_val = CTL_LF;
                        CH_R:    byte_val = CTL_CR;
                        CH_T:    byte_val = CTL_TAB;
                        default: byte_val = in_byte;
                    endcase
                    fin_en = end_of_input;
                end
            end

            // Plain text byte
            if (do_plain) begin
                mode_next = MODE_PLAIN;
                if (in_byte == CH_QUOTE) begin
                    fin_en = 1'b1;
                end else if (in_byte == CH_BSLASH) begin
                    if (end_of_input) begin
                        fin_en = 1'b1;
                    end else begin
                        mode_next = MODE_ESC;
                    end
                end else begin
                    byte_en = 1'b1;
                    fin_en  = end_of_input;
                end
            end

            if (fin_en) begin
                done_next = 1'b1;
                mode_next = MODE_PLAIN;
            end
        end
    end

    assign hi_enc = utf8_enc({5'b0, HI_SURR_TAG, held_reg});
    assign cp_enc = utf8_enc(cp_val);

    // Lay out the result list: surrogate, echoed digits, code point, byte, end
    always_comb begin
        res.item = '0;
        idx      = '0;
        pos      = '0;
        dig      = '0;
        if (emit_hi) begin
            for (int i = 0; i < 3; i++) begin
                res.item[idx[2:0]] = '{data: hi_enc.b[i], valid: 1'b1, last: 1'b0};
                idx = idx + RES_CNT_W'(1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < flush_n) begin
                pos = flush_n - 2'd1 - 2'(i);
                dig = flush_val[{pos, 2'b00} +: 4];
                if (dig < 4'd10) begin
                    res.item[idx[2:0]].data = 8'h30 + {4'b0, dig};
                end else if (flush_case[i]) begin
                    res.item[idx[2:0]].data = 8'h57 + {4'b0, dig};
                end else begin
                    res.item[idx[2:0]].data = 8'h37 + {4'b0, dig};
                end
                res.item[idx[2:0]].valid = 1'b1;
                res.item[idx[2:0]].last  = 1'b0;
                idx = idx + RES_CNT_W'(1);
            end
        end
        if (cp_en) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < cp_enc.len) begin
                    res.item[idx[2:0]] = '{data: cp_enc.b[i], valid: 1'b1, last: 1'b0};
                    idx = idx + RES_CNT_W'(1);
                end
            end
        end
        if (byte_en) begin
            res.item[idx[2:0]] = '{data: byte_val, valid: 1'b1, last: 1'b0};
            idx = idx + RES_CNT_W'(1);
        end
        if (fin_en) begin
            res.item[idx[2:0]] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
            idx = idx + RES_CNT_W'(1);
        end
        res.n = idx;
    end

    // Advance state on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            held_reg <= '0;
            case_reg <= '0;
            done_reg <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            held_reg <= held_next;
            case_reg <= case_next;
            done_reg <= done_next;
        end
    end

endmodule

/* hdl/jsu_outq.sv */
// Result register: holds one byte's result list and hands it out in order.
module jsu_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  jsu_pkg::dec_out_t res,
    input  logic              m_ready,
    output logic              can_load,
    output logic              m_valid,
    output logic [7:0]        m_out_byte,
    output logic              m_byte_valid,
    output logic              m_last
);
    import jsu_pkg::*;

    res_t [MAX_RES-1:0]   q_reg, q_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop;

    assign m_valid      = (cnt_reg != '0);
    assign pop          = m_valid && m_ready;
    assign can_load     = (cnt_reg == '0) || (cnt_reg == RES_CNT_W'(1) && m_ready);
    assign m_out_byte   = q_reg[0].data;
    assign m_byte_valid = q_reg[0].valid;
    assign m_last       = q_reg[0].last;

    // Load a new list, or shift one entry out per transfer
    always_comb begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (load) begin
            q_next   = res.item;
            cnt_next = res.n;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            cnt_next = cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

/* hdl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
//
//  channel  direction  payload                               handshake
//  s_       in         s_in_byte, s_end_of_input             s_valid / s_ready
//  m_       out        m_out_byte, m_byte_valid, m_last      m_valid / m_ready
//
// Each input byte is decoded in the cycle it transfers; its 0 to 8 result
// bytes are loaded into the result register. While m_ready is high they
// leave one per cycle, and a byte with at most one result is taken every
// cycle; after one with more results, the next input transfers in the cycle
// its last result does. Reset clears the decoder state and empties the
// result register. After the end marker, input bytes are taken and dropped.
module json_string_unescape_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_last
);
    import jsu_pkg::*;

    dec_out_t dec_res;
    logic     can_load;
    logic     take;

    assign s_ready = can_load;
    assign take    = s_valid && can_load;

    jsu_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .res          (dec_res)
    );

    jsu_outq u_outq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (take),
        .res          (dec_res),
        .m_ready      (m_ready),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last)
    );

endmodule

/* hdl/jsu_checker.sv */
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_last
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // The end marker carries no byte
    a_marker_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_byte_valid && m_out_byte == 8'h00)
        else $error("end marker carries a byte");

    // Every other result carries a byte
    a_data_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_byte_valid)
        else $error("result without byte before end marker");

    // Nothing follows the end marker transfer
    a_quiet_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("result after end marker");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_byte_valid) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_byte_valid   (m_byte_valid),
    .m_last         (m_last)
);
